FILE: hdl/maxstk_pkg.sv
// Shared types and constants of the max stack.
// Holds the stored entry layout, operation and status codes, and field widths.
// No dependencies.
`timescale 1ns / 1ps

package maxstk_pkg;

  // Field widths
  localparam int VAL_W  = 25;
  localparam int OCC_W  = 7;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  // Default number of stack entries
  localparam int DEFAULT_DEPTH = 64;

  // Operation codes carried by an input item
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_POP_MAX = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  // Status codes reported with each result
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // One stored entry: its value and the largest value at or below it
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] pmax;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/max_stack_with_pop_max.sv
// Top level of the max stack: command sequencer around one entry RAM.
// Depends on maxstk_pkg and maxstk_ram.
`timescale 1ns / 1ps

//  Channel  Ports                                   Handshake
//  ------   --------------------------------------  ------------------------------
//  input    in_func, in_push_value                  taken when start & !busy
//  result   out_removed_value, out_top_value,       valid for one cycle while
//           out_max_value, out_occupancy, out_status out_strobe is high
//
// Push, query, any failed removal and removal of the only entry finish in the
// accept cycle: out_strobe rises on the next cycle and busy stays low. Other pops
// of the top, or pop-maximum when the top is the maximum, hold busy in ST_POP_RD
// to read the new top from the RAM. Pop-maximum below the top scans down, then
// moves the entries above the hit down, one entry a cycle.
// Reset (rst_n low, synchronous) empties the stack; the receiver cannot stall.

module max_stack_with_pop_max #(
  parameter int STACK_DEPTH = maxstk_pkg::DEFAULT_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [maxstk_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [maxstk_pkg::VAL_W-1:0]  in_push_value,
  output logic                                 out_strobe,
  output logic signed [maxstk_pkg::VAL_W-1:0]  out_removed_value,
  output logic signed [maxstk_pkg::VAL_W-1:0]  out_top_value,
  output logic signed [maxstk_pkg::VAL_W-1:0]  out_max_value,
  output logic [maxstk_pkg::OCC_W-1:0]         out_occupancy,
  output logic [maxstk_pkg::STAT_W-1:0]        out_status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = maxstk_pkg::VAL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_SCAN,
    ST_BASE,
    ST_SHIFT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [VW-1:0]    top_r, top_nxt;
  logic signed [VW-1:0]    max_r, max_nxt;
  logic [AW-1:0]           scan_r, scan_nxt;
  logic [AW-1:0]           ra_r, ra_nxt;
  logic [AW-1:0]           wa_r, wa_nxt;
  logic signed [VW-1:0]    run_r, run_nxt;
  logic                    run_ok_r, run_ok_nxt;
  logic                    strobe_r, strobe_nxt;
  logic signed [VW-1:0]    removed_r, removed_nxt;
  logic signed [VW-1:0]    otop_r, otop_nxt;
  logic signed [VW-1:0]    omax_r, omax_nxt;
  logic [maxstk_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  maxstk_pkg::status_t     status_r, status_nxt;

  logic                    accept;
  logic [CW-1:0]           cnt_m1;
  logic [CW-1:0]           cnt_m2;
  logic signed [VW-1:0]    push_max;
  logic signed [VW-1:0]    shift_max;
  maxstk_pkg::func_t       func;
  maxstk_pkg::entry_t      rd_ent;
  maxstk_pkg::entry_t      wr_ent;
  logic [maxstk_pkg::ENTRY_W-1:0] ram_rdata;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [AW-1:0]           ram_raddr;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign func   = maxstk_pkg::func_t'(in_func);
  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);
  assign rd_ent = maxstk_pkg::entry_t'(ram_rdata);

  // Running maxima for a new top entry and for an entry moved down.
  assign push_max  = (cnt_r == '0 || in_push_value > max_r) ? in_push_value : max_r;
  assign shift_max = (!run_ok_r || rd_ent.val > run_r) ? rd_ent.val : run_r;

  // Entry storage.
  maxstk_ram #(
    .WIDTH (maxstk_pkg::ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: next state, RAM access and result values.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    top_nxt     = top_r;
    max_nxt     = max_r;
    scan_nxt    = scan_r;
    ra_nxt      = ra_r;
    wa_nxt      = wa_r;
    run_nxt     = run_r;
    run_ok_nxt  = run_ok_r;
    strobe_nxt  = 1'b0;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    ram_we      = 1'b0;
    ram_waddr   = wa_r;
    ram_raddr   = scan_r;
    wr_ent      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          removed_nxt = '0;
          status_nxt  = maxstk_pkg::STAT_OK;
          unique case (func)
            maxstk_pkg::FUNC_PUSH: begin
              strobe_nxt = 1'b1;
              if (cnt_r == CW'(STACK_DEPTH)) begin
                status_nxt = maxstk_pkg::STAT_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = cnt_r[AW-1:0];
                wr_ent.val  = in_push_value;
                wr_ent.pmax = push_max;
                top_nxt     = in_push_value;
                max_nxt     = push_max;
                cnt_nxt     = cnt_r + CW'(1);
              end
            end
            maxstk_pkg::FUNC_POP, maxstk_pkg::FUNC_POP_MAX: begin
              if (cnt_r == '0) begin
                status_nxt = maxstk_pkg::STAT_EMPTY;
                strobe_nxt = 1'b1;
              end else if (func == maxstk_pkg::FUNC_POP || top_r == max_r) begin
                // The entry to remove is the top itself.
                removed_nxt = top_r;
                if (cnt_r == CW'(1)) begin
                  cnt_nxt    = '0;
                  strobe_nxt = 1'b1;
                end else begin
                  ram_raddr = cnt_m2[AW-1:0];
                  state_nxt = ST_POP_RD;
                end
              end else begin
                // The maximum lies below the top: search downward for it.
                removed_nxt = max_r;
                ram_raddr   = cnt_m2[AW-1:0];
                scan_nxt    = cnt_m2[AW-1:0];
                state_nxt   = ST_SCAN;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_POP_RD: begin
        top_nxt    = rd_ent.val;
        max_nxt    = rd_ent.pmax;
        cnt_nxt    = cnt_m1;
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end

      ST_SCAN: begin
        // Read data belongs to scan_r; the next lower entry is read meanwhile.
        ram_raddr = scan_r - AW'(1);
        scan_nxt  = scan_r - AW'(1);
        if (rd_ent.val == max_r) begin
          wa_nxt = scan_r;
          if (scan_r == '0) begin
            ram_raddr  = AW'(1);
            ra_nxt     = AW'(2);
            run_ok_nxt = 1'b0;
            state_nxt  = ST_SHIFT;
          end else begin
            ra_nxt    = scan_r + AW'(1);
            state_nxt = ST_BASE;
          end
        end
      end

      ST_BASE: begin
        // Entry just below the removed one seeds the running maximum.
        run_nxt    = rd_ent.pmax;
        run_ok_nxt = 1'b1;
        ram_raddr  = ra_r;
        ra_nxt     = ra_r + AW'(1);
        state_nxt  = ST_SHIFT;
      end

      ST_SHIFT: begin
        // Move one entry down and rebuild its running maximum.
        ram_we      = 1'b1;
        ram_waddr   = wa_r;
        wr_ent.val  = rd_ent.val;
        wr_ent.pmax = shift_max;
        run_nxt     = shift_max;
        run_ok_nxt  = 1'b1;
        wa_nxt      = wa_r + AW'(1);
        ram_raddr   = ra_r;
        if (wa_r == cnt_m2[AW-1:0]) begin
          top_nxt    = rd_ent.val;
          max_nxt    = shift_max;
          cnt_nxt    = cnt_m1;
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          ra_nxt = ra_r + AW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Result fields reflect the stack after the operation.
    otop_nxt = (cnt_nxt != '0) ? top_nxt : '0;
    omax_nxt = (cnt_nxt != '0) ? max_nxt : '0;
    occ_nxt  = maxstk_pkg::OCC_W'(cnt_nxt);
    if (!strobe_nxt) begin
      otop_nxt = otop_r;
      omax_nxt = omax_r;
      occ_nxt  = occ_r;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
    top_r     <= top_nxt;
    max_r     <= max_nxt;
    scan_r    <= scan_nxt;
    ra_r      <= ra_nxt;
    wa_r      <= wa_nxt;
    run_r     <= run_nxt;
    run_ok_r  <= run_ok_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    otop_r    <= otop_nxt;
    omax_r    <= omax_nxt;
    occ_r     <= occ_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_removed_value = removed_r;
  assign out_top_value     = otop_r;
  assign out_max_value     = omax_r;
  assign out_occupancy     = occ_r;
  assign out_status        = status_r;

`ifndef ASSERT_OFF
  // The count never exceeds the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("entry count above capacity");

  // A result appears only once the sequencer is back at rest.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (state_r == ST_IDLE))
    else $error("result strobe while an operation is in progress");

  // The tracked maximum is never below the tracked top.
  a_max_ge_top: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (max_r >= top_r))
    else $error("maximum below top entry");

  // Moving entries down stays below the old top position.
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> ({1'b0, wa_r} < ({1'b0, cnt_r} - (CW + 1)'(1))))
    else $error("shift write beyond the stack");

  // A top pop sets the result strobe when it leaves ST_POP_RD.
  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_RD) |=> strobe_r)
    else $error("pop did not report its result");
`endif

endmodule

FILE: hdl/maxstk_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module maxstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
